// ----- rtl/core/qdel_pkg.sv -----
package qdel_pkg;

  // Operation codes carried on in_mode
  localparam logic [1:0] MODE_ENQ = 2'd0;
  localparam logic [1:0] MODE_DEQ = 2'd1;
  localparam logic [1:0] MODE_DEL = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 8;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [DATA_W-1:0]  removed_value;
    logic [COUNT_W-1:0]        count_after;
  } res_t;

endpackage

// ----- rtl/core/queue_with_delete_at_position.sv -----
// Result path: an enqueue, dequeue or rejected item goes from acceptance to the result state
//   S_FIN and then through the output register to out_valid; a delete at position p walks p slots first.
// Intake: in_ready is high only in S_IDLE, so a new item waits until the last result has left S_FIN;
//   a delete walk is paced by the single read port of the ring memory walking one entry per cycle.
// Reset: synchronous, active low; the queue comes up empty with the head at slot 0.
//   The ring memory is not cleared; only slots holding live elements are ever read.
module queue_with_delete_at_position #(
  parameter int DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic signed [31:0] in_push_value,
  input  logic [7:0]         in_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_removed_value,
  output logic [7:0]         out_count_after
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 8) ? CW : 8;

  // One-hot sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_COPY = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t         state_r, state_nxt;
  logic [AW-1:0]  head_r, head_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]  src_r, src_nxt;     // next slot to read during a rotation walk
  logic [AW-1:0]  dst_r, dst_nxt;     // next tail slot to write during the walk
  logic [CW-1:0]  left_r, left_nxt;   // reads still to issue
  logic           wr_pend_r, wr_pend_nxt;
  logic           last_r, last_nxt;
  logic [1:0]     res_status_r, res_status_nxt;
  logic [7:0]     res_cnt_r, res_cnt_nxt;
  logic           sel_rdata_r, sel_rdata_nxt;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [31:0]    mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  logic [31:0]    mem_rdata;

  logic           acc;
  logic [PW-1:0]  pos_ext;
  logic [PW-1:0]  cnt_ext;

  logic           res_valid;
  logic           res_ready;
  qdel_pkg::res_t res;
  qdel_pkg::res_t out_res;

  // Ring slot a + b, with b no larger than DEPTH
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, a} + {1'b0, b};
    if (s >= (CW + 1)'(DEPTH)) begin
      s = s - (CW + 1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // Count as it appears in the 8-bit result field
  function automatic logic [7:0] cnt8(input logic [CW-1:0] c);
    logic [PW-1:0] e;
    e = PW'(c);
    return e[7:0];
  endfunction

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign pos_ext  = PW'(in_position);
  assign cnt_ext  = PW'(cnt_r);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    cnt_nxt        = cnt_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    left_nxt       = left_r;
    wr_pend_nxt    = wr_pend_r;
    last_nxt       = last_r;
    res_status_nxt = res_status_r;
    res_cnt_nxt    = res_cnt_r;
    sel_rdata_nxt  = sel_rdata_r;
    mem_we         = 1'b0;
    mem_waddr      = head_r;
    mem_wdata      = in_push_value;
    mem_re         = 1'b0;
    mem_raddr      = head_r;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          state_nxt      = S_FIN;
          sel_rdata_nxt  = 1'b0;
          res_status_nxt = qdel_pkg::ST_OK;
          res_cnt_nxt    = cnt8(cnt_r);
          case (in_mode)
            qdel_pkg::MODE_ENQ: begin
              if (cnt_r == CW'(DEPTH)) begin
                res_status_nxt = qdel_pkg::ST_FULL;
              end else begin
                // Write the new tail in the accept cycle
                mem_we      = 1'b1;
                mem_waddr   = wrap_add(head_r, cnt_r);
                cnt_nxt     = cnt_r + 1'b1;
                res_cnt_nxt = cnt8(cnt_r + 1'b1);
              end
            end
            qdel_pkg::MODE_DEQ: begin
              if (cnt_r == '0) begin
                res_status_nxt = qdel_pkg::ST_EMPTY;
              end else begin
                mem_re        = 1'b1;
                mem_raddr     = head_r;
                head_nxt      = wrap_add(head_r, CW'(1));
                cnt_nxt       = cnt_r - 1'b1;
                res_cnt_nxt   = cnt8(cnt_r - 1'b1);
                sel_rdata_nxt = 1'b1;
              end
            end
            qdel_pkg::MODE_DEL: begin
              if (cnt_r == '0) begin
                res_status_nxt = qdel_pkg::ST_EMPTY;
              end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
                res_status_nxt = qdel_pkg::ST_BADPOS;
              end else begin
                // Walk p slots from the head: copy the first p-1 to the tail,
                // the p-th read returns the deleted value
                state_nxt   = S_COPY;
                src_nxt     = head_r;
                dst_nxt     = wrap_add(head_r, cnt_r);
                left_nxt    = pos_ext[CW-1:0];
                wr_pend_nxt = 1'b0;
                last_nxt    = 1'b0;
                head_nxt    = wrap_add(head_r, pos_ext[CW-1:0]);
                cnt_nxt     = cnt_r - 1'b1;
                res_cnt_nxt = cnt8(cnt_r - 1'b1);
              end
            end
            default: begin
              // Unused mode: report ok and leave the queue alone
            end
          endcase
        end
      end
      S_COPY: begin
        // Write back the entry read last cycle to the tail
        if (wr_pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = dst_r;
          mem_wdata = mem_rdata;
          dst_nxt   = wrap_add(dst_r, CW'(1));
        end
        if (left_r != '0) begin
          mem_re      = 1'b1;
          mem_raddr   = src_r;
          src_nxt     = wrap_add(src_r, CW'(1));
          left_nxt    = left_r - 1'b1;
          wr_pend_nxt = (left_r != CW'(1));
          last_nxt    = (left_r == CW'(1));
        end else begin
          wr_pend_nxt = 1'b0;
          last_nxt    = 1'b0;
        end
        // Read data now holds the deleted value
        if (last_r) begin
          state_nxt     = S_FIN;
          sel_rdata_nxt = 1'b1;
        end
      end
      S_FIN: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      cnt_r     <= '0;
      wr_pend_r <= 1'b0;
      last_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      cnt_r     <= cnt_nxt;
      wr_pend_r <= wr_pend_nxt;
      last_r    <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r        <= src_nxt;
    dst_r        <= dst_nxt;
    left_r       <= left_nxt;
    res_status_r <= res_status_nxt;
    res_cnt_r    <= res_cnt_nxt;
    sel_rdata_r  <= sel_rdata_nxt;
  end

  qdel_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Hand the finished result to the output register
  assign res_valid         = (state_r == S_FIN);
  assign res.status        = res_status_r;
  assign res.removed_value = sel_rdata_r ? mem_rdata : '0;
  assign res.count_after   = res_cnt_r;

  qdel_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (res_valid),
    .in_ready  (res_ready),
    .in_res    (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_status        = out_res.status;
  assign out_removed_value = out_res.removed_value;
  assign out_count_after   = out_res.count_after;

  // Occupancy never exceeds the ring size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("element count exceeds ring depth");

  // Memory writes come only from an accepted enqueue or the rotation walk
  a_we_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_COPY) || (acc && in_mode == qdel_pkg::MODE_ENQ))
    else $error("unexpected ring write");

  // The final walk read hands over to the result state
  a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY && last_r) |=> (state_r == S_FIN))
    else $error("walk did not finish into result state");

  // A successful enqueue grows the queue by one
  a_enq_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_mode == qdel_pkg::MODE_ENQ && cnt_r != CW'(DEPTH))
    |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("enqueue count update wrong");

endmodule

// ----- rtl/core/qdel_ram.sv -----
module qdel_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/qdel_outreg.sv -----
module qdel_outreg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  qdel_pkg::res_t   in_res,
  output logic             out_valid,
  input  logic             out_ready,
  output qdel_pkg::res_t   out_res
);

  logic           valid_r;
  qdel_pkg::res_t res_r;

  // Take a new result when empty or when the held one leaves this cycle
  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res_r <= in_res;
    end
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam int QUEUE_DEPTH = 128;
  // Longest quiet stretch: a delete at the deepest slot plus the pressure hold-off.
  localparam int STALL_LIMIT = 1000;
  // Cycles to watch for stray results once nothing is expected any more.
  localparam int SETTLE_CYCLES = 140;
  localparam logic [1:0] MODE_IDLE = 2'd3;  // unused code; the block must ignore it

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_mode;
  logic signed [31:0] in_push_value;
  logic [7:0]         in_position;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_status;
  logic signed [31:0] out_removed_value;
  logic [7:0]         out_count_after;

  // Contents of the queue as the block should hold them, head first.
  logic signed [31:0] shadow_queue[$];
  // Results owed by the block, oldest first.
  qdel_pkg::res_t     pending_results[$];

  int  error_count = 0;
  int  quiet_cycles = 0;
  int  hold_off_cycles = 0;
  bit  send_gaps = 1'b1;
  bit  recv_gaps = 1'b1;

  queue_with_delete_at_position #(
    .DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_push_value    (in_push_value),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_removed_value(out_removed_value),
    .out_count_after  (out_count_after)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one operation to the shadow queue and return the result it owes.
  // A delete walks the first pos-1 entries round to the tail, then pops the head.
  function automatic qdel_pkg::res_t apply_queue_op(logic [1:0] mode,
                                                    logic signed [31:0] value,
                                                    logic [7:0] pos);
    qdel_pkg::res_t r;
    r.status        = qdel_pkg::ST_OK;
    r.removed_value = '0;
    case (mode)
      qdel_pkg::MODE_ENQ: begin
        if (shadow_queue.size() >= QUEUE_DEPTH) r.status = qdel_pkg::ST_FULL;
        else shadow_queue.push_back(value);
      end
      qdel_pkg::MODE_DEQ: begin
        if (shadow_queue.size() == 0) r.status = qdel_pkg::ST_EMPTY;
        else r.removed_value = shadow_queue.pop_front();
      end
      qdel_pkg::MODE_DEL: begin
        if (shadow_queue.size() == 0) begin
          r.status = qdel_pkg::ST_EMPTY;
        end else if (pos == 0 || int'(pos) > shadow_queue.size()) begin
          r.status = qdel_pkg::ST_BADPOS;
        end else begin
          for (int i = 1; i < int'(pos); i++) shadow_queue.push_back(shadow_queue.pop_front());
          r.removed_value = shadow_queue.pop_front();
        end
      end
      default: ;  // unused code: no change, zero result
    endcase
    r.count_after = qdel_pkg::COUNT_W'(shadow_queue.size());
    return r;
  endfunction

  // Offer one item; return at the edge that accepts it, with valid still high,
  // so that a back-to-back item can follow without a dip in valid.
  task automatic send_item(input logic [1:0] mode, input logic signed [31:0] value,
                           input logic [7:0] pos);
    int gap;
    gap = send_gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_push_value <= value;
    in_position   <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_queue_op(mode, value, pos));
  endtask

  // Extremes of each field and every corner the queue can hit while small.
  task automatic test_directed_corners();
    send_item(qdel_pkg::MODE_DEQ, 32'sd0, 8'd0);             // dequeue from empty
    send_item(qdel_pkg::MODE_DEL, 32'sd0, 8'd1);             // delete from empty beats position check
    send_item(qdel_pkg::MODE_DEL, 32'sd0, 8'd0);             // empty and zero position together
    send_item(MODE_IDLE, 32'sd0, 8'd0);                      // unused code on an empty queue
    send_item(qdel_pkg::MODE_ENQ, 32'sh8000_0000, 8'hff);
    send_item(qdel_pkg::MODE_ENQ, 32'sh7fff_ffff, 8'h00);
    send_item(qdel_pkg::MODE_ENQ, 32'sd0, 8'd3);
    send_item(qdel_pkg::MODE_ENQ, -32'sd1, 8'd0);
    send_item(qdel_pkg::MODE_ENQ, 32'sh1234_5678, 8'd0);
    send_item(qdel_pkg::MODE_DEL, 32'sd0, 8'd0);             // zero position
    send_item(qdel_pkg::MODE_DEL, 32'sd0, 8'd6);             // one past the count
    send_item(qdel_pkg::MODE_DEL, 32'sd0, 8'd255);           // top of the field
    send_item(qdel_pkg::MODE_DEL, 32'sd0, 8'd128);
    send_item(MODE_IDLE, -32'sd1, 8'hff);                    // unused code with busy fields
    send_item(qdel_pkg::MODE_DEL, 32'sd0, 8'd5);             // last element
    send_item(qdel_pkg::MODE_DEL, 32'sd0, 8'd1);             // head element
    send_item(qdel_pkg::MODE_DEL, 32'sd0, 8'd2);             // middle element
    send_item(qdel_pkg::MODE_DEQ, 32'sd0, 8'd0);
    send_item(qdel_pkg::MODE_DEQ, -32'sd1, 8'hff);
    send_item(qdel_pkg::MODE_DEQ, 32'sd0, 8'd0);             // empty again
    send_item(qdel_pkg::MODE_DEL, 32'sd0, 8'd1);
  endtask

  // Fill to the top, push past it, and delete at the deepest slots.
  task automatic test_fill_to_full();
    repeat (QUEUE_DEPTH + 2) send_item(qdel_pkg::MODE_ENQ, $urandom(), 8'($urandom()));
    send_item(qdel_pkg::MODE_DEL, 32'sd0, 8'(QUEUE_DEPTH));  // tail of a full queue
    send_item(qdel_pkg::MODE_ENQ, $urandom(), 8'd0);
    send_item(qdel_pkg::MODE_ENQ, $urandom(), 8'd0);         // full again, dropped
    send_item(qdel_pkg::MODE_DEL, 32'sd0, 8'(QUEUE_DEPTH / 2));
    send_item(qdel_pkg::MODE_DEL, 32'sd0, 8'(QUEUE_DEPTH));  // one past the count
    send_item(qdel_pkg::MODE_DEL, 32'sd0, 8'(QUEUE_DEPTH - 1));
    repeat (20) send_item(qdel_pkg::MODE_DEQ, $urandom(), 8'($urandom()));
  endtask

  // Hold the result side off for a long stretch while items keep coming,
  // so the block's output backs up and it must drop in_ready.
  task automatic test_result_backpressure();
    send_gaps = 1'b0;
    hold_off_cycles = 100;
    for (int i = 0; i < 30; i++) begin
      if (i % 4 == 3) send_item(qdel_pkg::MODE_DEL, 32'sd0, 8'($urandom_range(0, 4)));
      else send_item(qdel_pkg::MODE_ENQ, $urandom(), 8'd0);
    end
    send_gaps = 1'b1;
  endtask

  // Random traffic; the enqueue bias swings so the depth sweeps up and down,
  // and idle gaps on either side switch off now and then.
  task automatic test_random_traffic(input int n_items);
    int          enq_weight;
    int          pick;
    int          depth_now;
    logic [7:0]  pos;
    enq_weight = 60;
    for (int i = 0; i < n_items; i++) begin
      if (i % 60 == 0) begin
        case ((i / 60) % 3)
          0:       enq_weight = 70;
          1:       enq_weight = 45;
          default: enq_weight = 25;
        endcase
        send_gaps = ($urandom_range(0, 3) != 0);
        recv_gaps = ($urandom_range(0, 3) != 0);
      end
      depth_now = shadow_queue.size();
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_item(MODE_IDLE, $urandom(), 8'($urandom()));
      end else if (pick < enq_weight) begin
        send_item(qdel_pkg::MODE_ENQ, $urandom(), 8'($urandom()));
      end else if (pick < (enq_weight + 100) / 2) begin
        send_item(qdel_pkg::MODE_DEQ, $urandom(), 8'($urandom()));
      end else begin
        pick = $urandom_range(0, 9);
        if (depth_now == 0 || pick == 0) pos = 8'($urandom());
        else if (pick == 1) pos = 8'd0;
        else if (pick == 2) pos = 8'(depth_now);
        else if (pick == 3) pos = 8'(depth_now + 1);
        else pos = 8'($urandom_range(1, depth_now));
        send_item(qdel_pkg::MODE_DEL, $urandom(), pos);
      end
    end
  endtask

  // Take results: draw a gap per item, and honor any long hold-off request.
  initial begin
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      gap = recv_gaps ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid && hold_off_cycles == 0) @(posedge clk);
    end
  end

  // Compare every accepted result with the oldest one owed.
  always @(posedge clk) begin
    qdel_pkg::res_t owed;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none owed: status %0d value %0d count %0d", $time,
                 out_status, out_removed_value, out_count_after);
        error_count++;
      end else begin
        owed = pending_results.pop_front();
        if (out_status !== owed.status) begin
          $display("%0t: status expected %0d actual %0d", $time, owed.status, out_status);
          error_count++;
        end
        if (out_removed_value !== owed.removed_value) begin
          $display("%0t: removed_value expected %0d actual %0d", $time,
                   owed.removed_value, out_removed_value);
          error_count++;
        end
        if (out_count_after !== owed.count_after) begin
          $display("%0t: count_after expected %0d actual %0d", $time,
                   owed.count_after, out_count_after);
          error_count++;
        end
      end
    end
  end

  // End the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results owed", $time, STALL_LIMIT,
               pending_results.size());
      $display("[queue_with_delete_at_position] ERROR");
      $finish;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_mode       <= qdel_pkg::MODE_ENQ;
    in_push_value <= '0;
    in_position   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_fill_to_full();
    test_result_backpressure();
    test_random_traffic(460);

    // Drop valid, drain what is owed, then watch for strays.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("[queue_with_delete_at_position] OK");
    end else begin
      $display("[queue_with_delete_at_position] ERROR");
    end
    $finish;
  end

endmodule
